### src/fkss_pkg.sv
package fkss_pkg;

   localparam int unsigned HashW   = 32;
   localparam int unsigned ByteW   = 8;
   localparam int unsigned ShardsW = 5;
   localparam int unsigned IndexW  = 4;

   localparam logic [HashW-1:0] FnvBasis = 32'd2166136261;
   localparam logic [HashW-1:0] FnvPrime = 32'd16777619;

   // shard_index is 4 bits wide, so no more than 16 shards can be told apart
   localparam int unsigned IndexLimit       = 16;
   localparam int unsigned MaxShardsDefault = 16;
   localparam int unsigned QueueDepth       = 2;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_WRITE
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### src/fnv1a_key_shard_select_unit.sv
// FNV-1a shard selector. Key bytes are pushed one per item and folded into a
// 32-bit FNV-1a hash at one item per clock while req_full is low. The item
// marked last places the finished hash in a two-entry queue and restarts the
// hash for the next key in the same cycle. A serial remainder unit then takes
// each hash from the queue and produces hash mod num_shards one dividend bit
// per cycle, so every key passes through the back end (load, 32 steps,
// write) before its shard index and hash appear on the rsp_ ports. Keys of
// many bytes therefore stream at full byte rate; a run of one-byte keys is
// bounded by the remainder loop once the queue fills. num_shards values of
// 0 act as 1, and values above the lesser of MAX_SHARDS and 16 act as that
// bound.
module fnv1a_key_shard_select_unit
   import fkss_pkg::*;
#(
   parameter int unsigned MAX_SHARDS = MaxShardsDefault
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [ByteW-1:0]     req_key_byte,
   input  logic                 req_byte_valid,
   input  logic                 req_last,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [IndexW-1:0]    rsp_shard_index,
   output logic [HashW-1:0]     rsp_key_hash,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [ShardsW-1:0]   csr_num_shards
);

   queue_status_type q_status;
   logic             hash_push;
   logic [HashW-1:0] hash_data;
   logic             q_pop;
   logic [HashW-1:0] q_data;
   logic             accept;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   fkss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .key_byte   (req_key_byte),
      .byte_valid (req_byte_valid),
      .last       (req_last),
      .hash_push  (hash_push),
      .hash_data  (hash_data)
   );

   fkss_queue #(
      .DEPTH (QueueDepth),
      .WIDTH (HashW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (hash_push),
      .push_data (hash_data),
      .pop       (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   fkss_back #(
      .MAX_SHARDS (MAX_SHARDS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_num_shards  (csr_num_shards),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_shard_index (rsp_shard_index),
      .rsp_key_hash    (rsp_key_hash)
   );

endmodule

### src/fkss_front.sv
module fkss_front
   import fkss_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [ByteW-1:0]     key_byte,
   input  logic                 byte_valid,
   input  logic                 last,
   output logic                 hash_push,
   output logic [HashW-1:0]     hash_data
);

   logic [HashW-1:0] running_ff;
   logic [HashW-1:0] running_in;
   logic [HashW-1:0] mixed;
   logic [HashW-1:0] step_hash;

   always_comb begin
      mixed     = running_ff ^ {{(HashW-ByteW){1'b0}}, key_byte};
      step_hash = byte_valid ? (mixed * FnvPrime) : running_ff;
      hash_push = accept && last;
      hash_data = step_hash;
      running_in = running_ff;
      if (accept) begin
         // restart from the offset basis once the key is complete
         running_in = last ? FnvBasis : step_hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= FnvBasis;
      end else begin
         running_ff <= running_in;
      end
   end

endmodule

### src/fkss_queue.sv
module fkss_queue
   import fkss_pkg::*;
#(
   parameter int unsigned DEPTH = QueueDepth,
   parameter int unsigned WIDTH = HashW
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [WIDTH-1:0]     push_data,
   input  logic                 pop,
   output logic [WIDTH-1:0]     pop_data,
   output queue_status_type     status
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
      logic [PtrW-1:0] result;
      if (ptr == PtrW'(DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + PtrW'(1);
      end
      return result;
   endfunction

   always_comb begin
      status.full  = (count_ff == CntW'(DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      pop_data     = entry_ff[rd_ptr_ff];
      wr_ptr_in    = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in    = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in     = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/fkss_back.sv
module fkss_back
   import fkss_pkg::*;
#(
   parameter int unsigned MAX_SHARDS = MaxShardsDefault
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  queue_status_type     q_status,
   input  logic [HashW-1:0]     q_data,
   output logic                 q_pop,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [ShardsW-1:0]   csr_num_shards,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [IndexW-1:0]    rsp_shard_index,
   output logic [HashW-1:0]     rsp_key_hash
);

   localparam int unsigned ShardCap = (MAX_SHARDS > IndexLimit) ? IndexLimit : MAX_SHARDS;
   localparam int unsigned StepW    = $clog2(HashW);

   back_state_type     state_ff, state_in;
   logic [ShardsW-1:0] shards_ff;
   logic [ShardsW-1:0] divisor;
   logic [HashW-1:0]   hash_ff;
   logic [HashW-1:0]   dividend_ff;
   logic [IndexW-1:0]  rem_ff, rem_in;
   logic [ShardsW-1:0] shifted;
   logic [StepW-1:0]   step_ff;
   logic               load;
   logic               advance;
   logic               write_out;
   logic               out_valid_ff;
   logic [IndexW-1:0]  out_index_ff;
   logic [HashW-1:0]   out_hash_ff;

   assign csr_ready       = 1'b1;
   assign rsp_empty       = !out_valid_ff;
   assign rsp_shard_index = out_index_ff;
   assign rsp_key_hash    = out_hash_ff;

   // a count of zero acts as one, a count above the cap acts as the cap
   always_comb begin
      divisor = shards_ff;
      if (shards_ff == '0) begin
         divisor = ShardsW'(1);
      end else if (shards_ff > ShardsW'(ShardCap)) begin
         divisor = ShardsW'(ShardCap);
      end
   end

   // restoring remainder, one dividend bit per cycle, MSB first
   always_comb begin
      shifted = {rem_ff, dividend_ff[HashW-1]};
      if (shifted >= divisor) begin
         rem_in = IndexW'(shifted - divisor);
      end else begin
         rem_in = shifted[IndexW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      load      = 1'b0;
      advance   = 1'b0;
      write_out = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               load     = 1'b1;
               state_in = BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            advance = 1'b1;
            if (step_ff == StepW'(HashW - 1)) begin
               state_in = BK_WRITE;
            end
         end
         BK_WRITE: begin
            // hold until the output register frees up
            if (!out_valid_ff || rsp_pop) begin
               write_out = 1'b1;
               state_in  = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hash_ff     <= q_data;
         dividend_ff <= q_data;
         rem_ff      <= '0;
         step_ff     <= '0;
      end else if (advance) begin
         dividend_ff <= {dividend_ff[HashW-2:0], 1'b0};
         rem_ff      <= rem_in;
         step_ff     <= step_ff + StepW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shards_ff    <= ShardsW'(1);
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            shards_ff <= csr_num_shards;
         end
         if (write_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (write_out) begin
         out_index_ff <= rem_ff;
         out_hash_ff  <= hash_ff;
      end
   end

endmodule

### tb/tb_fnv1a_key_shard_select_unit.sv
`timescale 1ns / 1ps

module tb_fnv1a_key_shard_select_unit;
   import fkss_pkg::*;

   localparam int unsigned MaxShards = MaxShardsDefault;
   localparam int unsigned HoldCycles = 300;

   typedef struct {
      logic [IndexW-1:0] shard;
      logic [HashW-1:0]  hash;
   } shard_pick_type;

   class shard_scoreboard;
      logic [HashW-1:0]   hash_acc;
      logic [ShardsW-1:0] shard_reg;
      shard_pick_type     pending_picks[$];
      int unsigned        errors;

      function new();
         hash_acc  = FnvBasis;
         shard_reg = ShardsW'(1);
         errors    = 0;
      endfunction

      function void write_shards(logic [ShardsW-1:0] value);
         shard_reg = value;
      endfunction

      // zero acts as one; anything past the index range or the build limit is clamped
      function int unsigned divisor();
         int unsigned n;
         n = 32'(shard_reg);
         if (n == 0) n = 1;
         if (n > IndexLimit) n = IndexLimit;
         if (n > MaxShards) n = MaxShards;
         return n;
      endfunction

      function void note_item(logic [ByteW-1:0] key_byte, logic byte_valid, logic last);
         shard_pick_type pick;
         if (byte_valid) hash_acc = (hash_acc ^ {24'd0, key_byte}) * FnvPrime;
         if (last) begin
            pick.hash  = hash_acc;
            pick.shard = IndexW'(hash_acc % divisor());
            pending_picks.push_back(pick);
            hash_acc = FnvBasis;
         end
      endfunction

      function int pending();
         return pending_picks.size();
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t ns: %s", $time, msg);
         errors++;
      endtask

      task check_pick(logic [IndexW-1:0] shard, logic [HashW-1:0] hash);
         shard_pick_type want;
         if (pending_picks.size() == 0) begin
            report_mismatch($sformatf("unexpected result shard %0d hash %08h", shard, hash));
            return;
         end
         want = pending_picks.pop_front();
         if (shard !== want.shard)
            report_mismatch($sformatf("shard_index %0d, want %0d (hash %08h)",
                                      shard, want.shard, want.hash));
         if (hash !== want.hash)
            report_mismatch($sformatf("key_hash %08h, want %08h", hash, want.hash));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [ByteW-1:0]    req_key_byte = '0;
   logic                req_byte_valid = 1'b0;
   logic                req_last = 1'b0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic [IndexW-1:0]   rsp_shard_index;
   logic [HashW-1:0]    rsp_key_hash;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [ShardsW-1:0]  csr_num_shards = '0;

   shard_scoreboard board = new();
   bit          idle_on = 1'b1;
   bit          hold_rsp = 1'b0;
   int unsigned items_sent = 0;

   fnv1a_key_shard_select_unit #(.MAX_SHARDS(MaxShards)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_key_byte    (req_key_byte),
      .req_byte_valid  (req_byte_valid),
      .req_last        (req_last),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_shard_index (rsp_shard_index),
      .rsp_key_hash    (rsp_key_hash),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_num_shards  (csr_num_shards)
   );

   always #5 clock = ~clock;

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic push_item(input logic [ByteW-1:0] key_byte, input logic byte_valid,
                            input logic last);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 13);
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push       = 1'b1;
      req_key_byte   = key_byte;
      req_byte_valid = byte_valid;
      req_last       = last;
      do @(posedge clock); while (req_full);
      board.note_item(key_byte, byte_valid, last);
      if (byte_valid || last) items_sent++;
      @(negedge clock);
   endtask

   task automatic send_key();
      int unsigned mode;
      int unsigned len;
      mode = $urandom_range(0, 99);
      if (mode < 80) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
         for (int i = 1; i <= len; i++)
            push_item(ByteW'($urandom_range(0, 255)), 1'b1, i == len);
      end else if (mode < 88) begin
         push_item(ByteW'($urandom_range(0, 255)), 1'b0, 1'b1);
      end else if (mode < 94) begin
         // valid bytes with ignored bytes mixed in
         len = $urandom_range(1, 6);
         for (int i = 1; i <= len; i++) begin
            if ($urandom_range(0, 1)) push_item(ByteW'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_item(ByteW'($urandom_range(0, 255)), 1'b1, i == len);
         end
      end else begin
         // invalid byte on the closing item
         len = $urandom_range(1, 4);
         repeat (len) push_item(ByteW'($urandom_range(0, 255)), 1'b1, 1'b0);
         push_item(ByteW'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
   endtask

   task automatic write_shards(input logic [ShardsW-1:0] value);
      req_push = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      // let the remainder loop settle before touching the divisor
      repeat (40) @(posedge clock);
      @(negedge clock);
      csr_valid      = 1'b1;
      csr_num_shards = value;
      do @(posedge clock); while (!csr_ready);
      board.write_shards(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      logic [ShardsW-1:0] settings[12];
      int unsigned target;
      settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd3, 5'd5, 5'd7, 5'd10, 5'd15,
                   5'd13};
      settings[11] = ShardsW'($urandom_range(0, 31));
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      push_item(8'h00, 1'b0, 1'b1);
      push_item(8'h00, 1'b1, 1'b1);
      push_item(8'hFF, 1'b1, 1'b1);
      push_item(8'h61, 1'b1, 1'b1);
      push_item(8'hA5, 1'b0, 1'b0);
      push_item(8'h5A, 1'b1, 1'b1);
      push_item(8'h01, 1'b1, 1'b0);
      push_item(8'h80, 1'b1, 1'b0);
      push_item(8'hFF, 1'b0, 1'b1);
      push_item(8'hFF, 1'b0, 1'b0);
      push_item(8'h00, 1'b0, 1'b1);
      push_item(8'h7F, 1'b1, 1'b0);
      push_item(8'hFE, 1'b1, 1'b0);
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'hFF, 1'b1, 1'b1);

      foreach (settings[p]) begin
         write_shards(settings[p]);
         if (p == 3) hold_rsp = 1'b1;
         if (p == 11) idle_on = 1'b0;
         target = items_sent + 60;
         while (items_sent < target) send_key();
      end
      req_push = 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.errors == 0)
         $display("tb_fnv1a_key_shard_select_unit passed");
      else
         $display("tb_fnv1a_key_shard_select_unit failed");
      $finish;
   end

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            // stall long enough for the block to back up into req_full
            rsp_pop = 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_pop = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_pop = 1'b1;
         @(posedge clock);
         if (!rsp_empty) board.check_pick(rsp_shard_index, rsp_key_hash);
         @(negedge clock);
      end
   end

   initial begin
      #5_000_000;
      $display("tb_fnv1a_key_shard_select_unit failed");
      $finish;
   end

endmodule

### filelist.f
src/fkss_pkg.sv
src/fkss_front.sv
src/fkss_queue.sv
src/fkss_back.sv
src/fnv1a_key_shard_select_unit.sv
tb/tb_fnv1a_key_shard_select_unit.sv
